>>> rtl/core/cds420_pkg.sv
package cds420_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_DW = 12;
	localparam int CFG_IW = 1;
	localparam int ROW_W = 11;
	localparam int MAX_HEIGHT = 2048;
	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;

	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [1:0] KIND_LUMA = 2'd0;
	localparam logic [1:0] KIND_U = 2'd1;
	localparam logic [1:0] KIND_V = 2'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW = $clog2(FIFO_DEPTH + 1);
	localparam logic [FIFO_LW-1:0] FIFO_FULL_LEVEL = FIFO_LW'(FIFO_DEPTH);

	typedef struct packed {
		logic [BYTE_W-1:0] luma_in;
		logic [BYTE_W-1:0] chroma_u_in;
		logic [BYTE_W-1:0] chroma_v_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0] sample_kind;
		logic [BYTE_W-1:0] sample_value;
		logic run_last;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] luma;
		logic has_chroma;
		logic frame_end;
		logic [BYTE_W-1:0] u_avg;
		logic [BYTE_W-1:0] v_avg;
	} job_t;

endpackage

>>> rtl/core/cds420_front.sv
module cds420_front #(
	parameter int MAX_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cds420_pkg::CFG_IW-1:0] cfg_index,
	input  logic [cds420_pkg::CFG_DW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  cds420_pkg::in_item_t in_data,
	input  logic [cds420_pkg::FIFO_LW-1:0] fifo_level,
	output logic push_valid,
	output cds420_pkg::job_t push_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PAIR_DEPTH = MAX_WIDTH / 2;
	localparam int AW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
	localparam int CLW = ($clog2(MAX_WIDTH + 1) > cds420_pkg::CFG_DW) ?
		$clog2(MAX_WIDTH + 1) : cds420_pkg::CFG_DW;
	localparam int W_RST = (cds420_pkg::WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : cds420_pkg::WIDTH_RESET;
	localparam int H_RST = (cds420_pkg::HEIGHT_RESET > cds420_pkg::MAX_HEIGHT) ?
		cds420_pkg::MAX_HEIGHT : cds420_pkg::HEIGHT_RESET;
	localparam logic [CW-1:0] WLAST_RST = CW'(W_RST - 1);
	localparam logic [cds420_pkg::ROW_W-1:0] HLAST_RST = cds420_pkg::ROW_W'(H_RST - 1);
	localparam logic [CLW-1:0] MAXW = CLW'(MAX_WIDTH);
	localparam logic [cds420_pkg::CFG_DW-1:0] MAXH =
		cds420_pkg::CFG_DW'(cds420_pkg::MAX_HEIGHT);
	localparam int PW = cds420_pkg::BYTE_W + 1;

	logic [CW-1:0] wlast_q;
	logic [cds420_pkg::ROW_W-1:0] hlast_q;
	logic [CW-1:0] col_q;
	logic [cds420_pkg::ROW_W-1:0] row_q;
	logic [cds420_pkg::BYTE_W-1:0] held_u_q;
	logic [cds420_pkg::BYTE_W-1:0] held_v_q;

	logic [2*PW-1:0] line_mem [PAIR_DEPTH];
	logic [2*PW-1:0] line_rd_s1;

	logic valid_s1;
	logic [cds420_pkg::BYTE_W-1:0] luma_s1;
	logic chroma_s1;
	logic frame_end_s1;
	logic [PW-1:0] pair_u_s1;
	logic [PW-1:0] pair_v_s1;

	logic [CLW-1:0] w_ext;
	logic [CLW-1:0] w_clamp;
	logic [cds420_pkg::CFG_DW-1:0] h_clamp;
	logic [cds420_pkg::FIFO_LW:0] committed;
	logic accept;
	logic row_end;
	logic frame_end;
	logic [PW-1:0] pair_u;
	logic [PW-1:0] pair_v;
	logic [AW-1:0] slot;
	logic line_we;
	logic [PW:0] sum_u;
	logic [PW:0] sum_v;

	assign w_ext = CLW'(cfg_data);

	always_comb begin
		if (cfg_data == '0) begin
			w_clamp = CLW'(1);
			h_clamp = cds420_pkg::CFG_DW'(1);
		end else begin
			w_clamp = (w_ext > MAXW) ? MAXW : w_ext;
			h_clamp = (cfg_data > MAXH) ? MAXH : cfg_data;
		end
	end

	assign committed = {1'b0, fifo_level} + {{cds420_pkg::FIFO_LW{1'b0}}, valid_s1};
	assign in_stall = committed >= {1'b0, cds420_pkg::FIFO_FULL_LEVEL};
	assign accept = in_valid && !in_stall;

	assign row_end = col_q >= wlast_q;
	assign frame_end = row_end && (row_q >= hlast_q);
	assign pair_u = {1'b0, held_u_q} + {1'b0, in_data.chroma_u_in};
	assign pair_v = {1'b0, held_v_q} + {1'b0, in_data.chroma_v_in};
	assign slot = AW'(col_q >> 1);
	assign line_we = accept && col_q[0] && !row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= WLAST_RST;
			hlast_q <= HLAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cds420_pkg::CFG_FRAME_WIDTH: wlast_q <= CW'(w_clamp - CLW'(1));
				cds420_pkg::CFG_FRAME_HEIGHT: hlast_q <=
					cds420_pkg::ROW_W'(h_clamp - cds420_pkg::CFG_DW'(1));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			held_u_q <= '0;
			held_v_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				held_u_q <= in_data.chroma_u_in;
				held_v_q <= in_data.chroma_v_in;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[slot] <= {pair_u, pair_v};
		end
		if (accept) begin
			line_rd_s1 <= line_mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1 <= in_data.luma_in;
			chroma_s1 <= col_q[0] && row_q[0];
			frame_end_s1 <= frame_end;
			pair_u_s1 <= pair_u;
			pair_v_s1 <= pair_v;
		end
	end

	assign sum_u = {1'b0, line_rd_s1[2*PW-1:PW]} + {1'b0, pair_u_s1};
	assign sum_v = {1'b0, line_rd_s1[PW-1:0]} + {1'b0, pair_v_s1};

	assign push_valid = valid_s1;
	assign push_data.luma = luma_s1;
	assign push_data.has_chroma = chroma_s1;
	assign push_data.frame_end = frame_end_s1;
	assign push_data.u_avg = sum_u[PW:2];
	assign push_data.v_avg = sum_v[PW:2];

endmodule

>>> rtl/core/cds420_fifo.sv
module cds420_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cds420_pkg::job_t push_data,
	input  logic pop,
	output cds420_pkg::job_t head,
	output logic head_valid,
	output logic [cds420_pkg::FIFO_LW-1:0] level
);

	cds420_pkg::job_t entries_q [cds420_pkg::FIFO_DEPTH];
	logic [cds420_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [cds420_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [cds420_pkg::FIFO_LW-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign head = entries_q[rd_ptr_q];
	assign head_valid = level_q != '0;
	assign level = level_q;

endmodule

>>> rtl/core/cds420_back.sv
module cds420_back (
	input  logic clk,
	input  logic arst_n,
	input  cds420_pkg::job_t head,
	input  logic head_valid,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output cds420_pkg::out_item_t out_data
);

	typedef enum logic [1:0] {
		PH_LUMA,
		PH_U,
		PH_V
	} phase_t;

	phase_t phase_q;
	logic out_valid_q;
	cds420_pkg::out_item_t out_data_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign pop = out_free && head_valid &&
		((phase_q == PH_LUMA && !head.has_chroma) || phase_q == PH_V);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LUMA;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else if (out_free) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				unique case (phase_q)
					PH_LUMA: begin
						out_data_q.sample_kind <= cds420_pkg::KIND_LUMA;
						out_data_q.sample_value <= head.luma;
						out_data_q.run_last <= !head.has_chroma;
						out_data_q.frame_done <= !head.has_chroma && head.frame_end;
						phase_q <= head.has_chroma ? PH_U : PH_LUMA;
					end
					PH_U: begin
						out_data_q.sample_kind <= cds420_pkg::KIND_U;
						out_data_q.sample_value <= head.u_avg;
						out_data_q.run_last <= 1'b0;
						out_data_q.frame_done <= 1'b0;
						phase_q <= PH_V;
					end
					PH_V: begin
						out_data_q.sample_kind <= cds420_pkg::KIND_V;
						out_data_q.sample_value <= head.v_avg;
						out_data_q.run_last <= 1'b1;
						out_data_q.frame_done <= head.frame_end;
						phase_q <= PH_LUMA;
					end
					default: begin
						phase_q <= PH_LUMA;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

>>> rtl/core/yuv444_to_420sp_chroma_downsample_top.sv
// 4:4:4 YUV to 4:2:0 semi-planar chroma downsampler.
// Input channel (in_valid/in_stall/in_data): one packed Y, U, V pixel per
// transaction, raster order, frame size set by frame_width / frame_height
// (config indexes 0 and 1, written with cfg_we while the block is idle).
// Output channel (out_valid/out_stall/out_data): one byte per transaction,
// tagged luma, averaged U or averaged V. Every pixel yields its luma byte;
// the odd column of an odd row then yields the 2x2 block's U and V averages.
// run_last marks a pixel's final byte, frame_done the frame's final byte.
// The luma byte passes the front stage register, job queue and output
// register, the chroma bytes after it. The output register moves one byte
// a cycle unless stalled, so a pixel costs 1 or 3 output bytes, 1.5 on
// average over a 2x2 block; a pixel may enter every cycle while the 4-entry
// job queue has room. The line store of even-row pair sums is one read/write
// port RAM of MAX_WIDTH/2 entries, one access per pixel.
// When the receiver stalls, the output byte holds, the queue fills, and then
// in_stall rises. Reset clears position counters, held chroma, queue and
// output; the line store is not cleared and needs no init pass.
module yuv444_to_420sp_chroma_downsample_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cds420_pkg::CFG_IW-1:0] cfg_index,
	input  logic [cds420_pkg::CFG_DW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  cds420_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output cds420_pkg::out_item_t out_data
);

	logic push_valid;
	cds420_pkg::job_t push_data;
	logic pop;
	cds420_pkg::job_t head;
	logic head_valid;
	logic [cds420_pkg::FIFO_LW-1:0] fifo_level;

	cds420_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.fifo_level(fifo_level),
		.push_valid(push_valid),
		.push_data(push_data)
	);

	cds420_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push_valid),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.head_valid(head_valid),
		.level(fifo_level)
	);

	cds420_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (fifo_level != cds420_pkg::FIFO_FULL_LEVEL))
		else $error("job queue overflow");

	a_u_then_v: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.sample_kind == cds420_pkg::KIND_U)
		|=> (out_valid && out_data.sample_kind == cds420_pkg::KIND_V))
		else $error("averaged U not followed by averaged V");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_done) |-> out_data.run_last)
		else $error("frame_done without run_last");
`endif

endmodule
